// ----- hw/rtl/tlrg_pkg.sv -----
// shared types and constants of the thin lens primary ray generator
package tlrg_pkg;

  // fixed point widths
  localparam int unsigned COMP_W = 21;  // packed vector component, Q11.10 or Q2.19
  localparam int unsigned VEC_W  = 64;  // wide vector ahead of normalization
  localparam int unsigned DIR_W  = 32;  // unit direction component, Q2.30

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_EYE    = 3'd0,
    CFG_CORNER = 3'd1,
    CFG_RIGHT  = 3'd2,
    CFG_UP     = 3'd3,
    CFG_VIEW   = 3'd4,
    CFG_STEPS  = 3'd5,
    CFG_LENS   = 3'd6
  } cfg_idx_e;

  // per-ray data riding along the first normalizer
  typedef struct packed {
    logic        use_lens;
    logic [31:0] shutter_time;
    logic [15:0] lens_x;
    logic [15:0] lens_y;
  } side1_t;

  // per-ray data riding along the second normalizer
  typedef struct packed {
    logic                  use_lens;
    logic [31:0]           shutter_time;
    logic [2:0][31:0]      org;
    logic [2:0][DIR_W-1:0] dir;
  } side2_t;

endpackage

// ----- hw/rtl/tlrg_norm.sv -----
// pipelined vector normalizer: prescale, square sum, square root, three dividers
module tlrg_norm #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic signed [tlrg_pkg::VEC_W-1:0]    vec_i [3],
  input  logic [SIDE_W-1:0]                    side_i,
  output logic                                 valid_o,
  output logic signed [tlrg_pkg::DIR_W-1:0]    dir_o [3],
  output logic [SIDE_W-1:0]                    side_o
);
  import tlrg_pkg::*;

  localparam int unsigned RT_N = 32;  // root bits, one per stage
  localparam int unsigned DV_N = 31;  // quotient bits, one per stage
  localparam int unsigned LAT  = 6 + RT_N + DV_N + 1;
  localparam int unsigned LW   = SIDE_W + 3;

  // bit length of one byte
  function automatic logic [3:0] bl8(input logic [7:0] x);
    logic [3:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (x[k]) r = 4'(k + 1);
    end
    return r;
  endfunction

  // valid and sideband delay line, sign bits in the low three bits
  logic          vld_q  [LAT];
  logic [LW-1:0] line_q [LAT];
  logic [2:0]    neg_w;

  always_comb begin
    for (int i = 0; i < 3; i++) neg_w[i] = vec_i[i][VEC_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= {side_i, neg_w};
      for (int k = 1; k < LAT; k++) line_q[k] <= line_q[k-1];
    end
  end

  // magnitudes
  logic [VEC_W-1:0] a0_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        a0_q[i] <= vec_i[i][VEC_W-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
      end
    end
  end

  // bit length per byte of the combined magnitude
  logic [VEC_W-1:0] orv_w;
  logic [VEC_W-1:0] a1_q [3];
  logic [3:0]       grp_q [8];
  assign orv_w = a0_q[0] | a0_q[1] | a0_q[2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= a0_q;
      for (int g = 0; g < 8; g++) grp_q[g] <= bl8(orv_w[g*8 +: 8]);
    end
  end

  // bit length of the largest magnitude
  logic [6:0]       bl_d, bl_q;
  logic [VEC_W-1:0] a2_q [3];
  always_comb begin
    bl_d = '0;
    for (int g = 0; g < 8; g++) begin
      if (grp_q[g] != 4'd0) bl_d = 7'(g * 8) + 7'(grp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q <= a1_q;
      bl_q <= bl_d;
    end
  end

  // scale so that the largest magnitude has 31 bits
  logic [30:0] as3_d [3];
  logic [30:0] as3_q [3];
  always_comb begin
    logic [VEC_W-1:0] t;
    for (int i = 0; i < 3; i++) begin
      if (bl_q > 7'd31) t = a2_q[i] >> (bl_q - 7'd31);
      else              t = a2_q[i] << (7'd31 - bl_q);
      as3_d[i] = t[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) as3_q <= as3_d;
  end

  // squares
  logic [61:0] sq4_q [3];
  logic [30:0] as4_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sq4_q[i] <= as3_q[i] * as3_q[i];
      as4_q <= as3_q;
    end
  end

  // sum of squares
  logic [63:0] sum5_q;
  logic [30:0] as5_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum5_q <= 64'(sq4_q[0]) + 64'(sq4_q[1]) + 64'(sq4_q[2]);
      as5_q  <= as4_q;
    end
  end

  // square root, one result bit per stage
  logic [63:0] rt_n_q [RT_N];
  logic [63:0] rt_r_q [RT_N];
  logic [30:0] rt_a_q [RT_N][3];

  for (genvar k = 0; k < RT_N; k++) begin : g_root
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] n_in, r_in, tr;
    logic [30:0] a_in [3];
    if (k == 0) begin : g_first
      assign n_in = sum5_q;
      assign r_in = '0;
      assign a_in = as5_q;
    end else begin : g_next
      assign n_in = rt_n_q[k-1];
      assign r_in = rt_r_q[k-1];
      assign a_in = rt_a_q[k-1];
    end
    assign tr = r_in + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (n_in >= tr) begin
          rt_n_q[k] <= n_in - tr;
          rt_r_q[k] <= (r_in >> 1) + BIT;
        end else begin
          rt_n_q[k] <= n_in;
          rt_r_q[k] <= r_in >> 1;
        end
        rt_a_q[k] <= a_in;
      end
    end
  end

  // length, zero taken as one
  logic [31:0] len_w;
  assign len_w = (rt_r_q[RT_N-1][31:0] == 32'd0) ? 32'd1 : rt_r_q[RT_N-1][31:0];

  // restoring dividers, magnitude * 2^30 / length
  logic [31:0] dv_r_q [DV_N][3];
  logic [30:0] dv_q_q [DV_N][3];
  logic [31:0] dv_l_q [DV_N];

  for (genvar j = 0; j < DV_N; j++) begin : g_div
    logic [31:0] r_in [3];
    logic [30:0] q_in [3];
    logic [2:0]  b_in;
    logic [31:0] l_in;
    if (j == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_c
        assign r_in[i] = {2'b00, rt_a_q[RT_N-1][i][30:1]};
        assign q_in[i] = '0;
        assign b_in[i] = rt_a_q[RT_N-1][i][0];
      end
      assign l_in = len_w;
    end else begin : g_next
      assign r_in = dv_r_q[j-1];
      assign q_in = dv_q_q[j-1];
      assign b_in = '0;
      assign l_in = dv_l_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      logic [32:0] rem2;
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          rem2 = {r_in[i], b_in[i]};
          if (rem2 >= {1'b0, l_in}) begin
            dv_r_q[j][i] <= 32'(rem2 - {1'b0, l_in});
            dv_q_q[j][i] <= {q_in[i][29:0], 1'b1};
          end else begin
            dv_r_q[j][i] <= rem2[31:0];
            dv_q_q[j][i] <= {q_in[i][29:0], 1'b0};
          end
        end
        dv_l_q[j] <= l_in;
      end
    end
  end

  // reapply signs
  logic signed [DIR_W-1:0] dir_q [3];
  always_ff @(posedge clk_i) begin
    logic signed [DIR_W-1:0] m;
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m = $signed({1'b0, dv_q_q[DV_N-1][i]});
        dir_q[i] <= line_q[LAT-2][i] ? -m : m;
      end
    end
  end

  assign valid_o = vld_q[LAT-1];
  assign dir_o   = dir_q;
  assign side_o  = line_q[LAT-1][LW-1:3];

`ifndef NO_ASSERTIONS
  // a unit vector component never exceeds one
  a_dir_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (dir_q[0] <= 32'sh4000_0000 && dir_q[0] >= -32'sh4000_0000 &&
                 dir_q[1] <= 32'sh4000_0000 && dir_q[1] >= -32'sh4000_0000 &&
                 dir_q[2] <= 32'sh4000_0000 && dir_q[2] >= -32'sh4000_0000))
    else $error("normalized component out of range");

  // a stall freezes the output valid
  a_stall_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_o))
    else $error("normalizer output moved during stall");

  // output valid is always known
  a_valid_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(valid_o))
    else $error("normalizer output valid unknown");
`endif

endmodule

// ----- hw/rtl/thin_lens_primary_ray_gen.sv -----
// Thin lens primary ray generator: one camera ray per pixel sample, pinhole or
// depth of field. A sample is taken every cycle while the output is not held;
// the pipeline runs through two normalizers of 70 stages each (square root
// and divide, one bit per stage) and the 32-stage focal length divider. The
// whole pipeline holds together while a finished ray is not taken. The
// configuration registers may be written only while no ray is in flight.
module thin_lens_primary_ray_gen #(
  parameter int unsigned PIXEL_INDEX_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [63:0]                   cfg_data_i,
  // samples
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [PIXEL_INDEX_BITS-1:0]   row_i,
  input  logic [PIXEL_INDEX_BITS-1:0]   col_i,
  input  logic                          use_lens_i,
  input  logic signed [31:0]            shutter_time_i,
  input  logic [15:0]                   sub_x_i,
  input  logic [15:0]                   sub_y_i,
  input  logic signed [15:0]            lens_x_i,
  input  logic signed [15:0]            lens_y_i,
  // rays
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            origin_x_o,
  output logic signed [31:0]            origin_y_o,
  output logic signed [31:0]            origin_z_o,
  output logic signed [31:0]            dir_x_o,
  output logic signed [31:0]            dir_y_o,
  output logic signed [31:0]            dir_z_o,
  output logic signed [31:0]            ray_time_o
);
  import tlrg_pkg::*;

  localparam int unsigned UW    = PIXEL_INDEX_BITS + 16;  // pixel coordinate with subpixel
  localparam int unsigned SUW   = UW + 8;                 // scaled step, 20 fraction bits
  localparam int unsigned PW    = SUW + COMP_W + 1;       // step times axis
  localparam int unsigned CW    = 34;                     // cosine, Q4.30
  localparam int unsigned FD_N  = 32;                     // focal quotient bits
  localparam int unsigned S1_W  = $bits(side1_t);
  localparam int unsigned S2_W  = $bits(side2_t);

  // component i of a packed register
  function automatic logic signed [COMP_W-1:0] comp(input logic [62:0] r,
                                                     input int unsigned i);
    return $signed(r[COMP_W*i +: COMP_W]);
  endfunction

  // shift right truncating toward zero
  function automatic logic signed [63:0] shr0(input logic signed [63:0] x,
                                              input int unsigned s);
    logic [63:0] m;
    logic [63:0] r;
    m = x[63] ? (~x + 1'b1) : x;
    r = m >> s;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

  // clamp to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647)       return 32'h7fff_ffff;
    else if (x < -64'sd2147483648) return 32'h8000_0000;
    else                           return x[31:0];
  endfunction

  // configuration registers
  logic [62:0] eye_q, corner_q, right_q, up_q, view_q;
  logic [63:0] steps_q, lens_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_q    <= '0;
      corner_q <= '0;
      right_q  <= '0;
      up_q     <= '0;
      view_q   <= '0;
      steps_q  <= '0;
      lens_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_EYE:    eye_q    <= cfg_data_i[62:0];
        CFG_CORNER: corner_q <= cfg_data_i[62:0];
        CFG_RIGHT:  right_q  <= cfg_data_i[62:0];
        CFG_UP:     up_q     <= cfg_data_i[62:0];
        CFG_VIEW:   view_q   <= cfg_data_i[62:0];
        CFG_STEPS:  steps_q  <= cfg_data_i;
        CFG_LENS:   lens_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being emptied
  logic out_valid_q;
  logic en;
  assign en         = ~out_valid_q | out_ready_i;
  assign in_ready_o = en;

  // stage a: pixel offsets times steps
  logic [UW+31:0] hprod_w, vprod_w;
  logic [SUW-1:0] su_q, sv_q;
  logic           va_q;
  side1_t         sa_q;
  assign hprod_w = {col_i, sub_x_i} * steps_q[31:0];
  assign vprod_w = {row_i, sub_y_i} * steps_q[63:32];

  always_ff @(posedge clk_i) begin
    if (en) begin
      su_q <= hprod_w[UW+31:24];
      sv_q <= vprod_w[UW+31:24];
      sa_q <= '{use_lens: use_lens_i, shutter_time: shutter_time_i,
                lens_x: lens_x_i, lens_y: lens_y_i};
    end
  end

  // stage b: offsets along the image plane axes
  logic signed [PW-1:0] pr_q [3];
  logic signed [PW-1:0] pu_q [3];
  logic                 vb_q;
  side1_t               sb_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr_q[i] <= $signed({1'b0, su_q}) * comp(right_q, i);
        pu_q[i] <= $signed({1'b0, sv_q}) * comp(up_q, i);
      end
      sb_q <= sa_q;
    end
  end

  // stage c: pixel point minus eye, 39 fraction bits
  logic signed [VEC_W-1:0] diff_q [3];
  logic                    vc_q;
  side1_t                  sc_q;
  always_ff @(posedge clk_i) begin
    logic signed [COMP_W:0] ce;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ce = (COMP_W+1)'(comp(corner_q, i)) - (COMP_W+1)'(comp(eye_q, i));
        diff_q[i] <= VEC_W'(pr_q[i]) - VEC_W'(pu_q[i]) + (VEC_W'(ce) <<< 29);
      end
      sc_q <= sb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // first normalizer: view direction through the pixel
  logic                    n1_valid;
  logic signed [DIR_W-1:0] d1 [3];
  logic [S1_W-1:0]         n1_side;
  side1_t                  s1;

  tlrg_norm #(.SIDE_W(S1_W)) u_norm_pix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc_q),
    .vec_i   (diff_q),
    .side_i  (sc_q),
    .valid_o (n1_valid),
    .dir_o   (d1),
    .side_o  (n1_side)
  );
  assign s1 = side1_t'(n1_side);

  // stage e: cosine terms and aperture offset terms
  logic signed [DIR_W+COMP_W-1:0] dp_q [3];
  logic signed [COMP_W+15:0]      cu_q [3];
  logic signed [COMP_W+15:0]      cr_q [3];
  logic signed [DIR_W-1:0]        de_q [3];
  logic                           ve_q;
  side1_t                         se_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dp_q[i] <= d1[i] * comp(view_q, i);
        cu_q[i] <= comp(up_q, i) * $signed(s1.lens_y);
        cr_q[i] <= comp(right_q, i) * $signed(s1.lens_x);
      end
      de_q <= d1;
      se_q <= s1;
    end
  end

  // stage f: cosine to Q4.30 with floor at one lsb, aperture offset to Q1.19
  logic [CW-1:0]        cosv_d, cosv_q;
  logic signed [23:0]   cs_d [3];
  logic signed [23:0]   cs_q [3];
  logic signed [DIR_W-1:0] df_q [3];
  logic                 vf_q;
  side1_t               sf_q;
  always_comb begin
    logic signed [63:0] dot, cosl, cb;
    dot = 64'(dp_q[0]) + 64'(dp_q[1]) + 64'(dp_q[2]);
    cosl = shr0(dot, 19);
    cosv_d = (cosl <= 64'sd0) ? CW'(1) : cosl[CW-1:0];
    for (int i = 0; i < 3; i++) begin
      cb = shr0(64'(cu_q[i]) + 64'(cr_q[i]), 14);
      cs_d[i] = cb[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cosv_q <= cosv_d;
      cs_q   <= cs_d;
      df_q   <= de_q;
      sf_q   <= se_q;
    end
  end

  // stage g: aperture point and divider set-up
  typedef struct packed {
    logic [CW-1:0]          rem;
    logic [FD_N-1:0]        q;
    logic [CW-1:0]          cosv;
    logic                   ovf;
    logic [2:0][63:0]       ap;
    logic [2:0][DIR_W-1:0]  d;
    side1_t                 side;
  } fdiv_t;

  fdiv_t fg_q;
  logic  vg_q;
  always_ff @(posedge clk_i) begin
    logic signed [56:0] apm;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        apm = cs_q[i] * $signed({1'b0, lens_q[31:0]});
        fg_q.ap[i] <= 64'(apm) + (64'(comp(eye_q, i)) <<< 26);
        fg_q.d[i]  <= df_q[i];
      end
      fg_q.rem  <= CW'(lens_q[63:34]);
      fg_q.q    <= '0;
      fg_q.cosv <= cosv_q;
      fg_q.ovf  <= CW'(lens_q[63:34]) >= cosv_q;
      fg_q.side <= sf_q;
    end
  end

  // focal length divider, focus * 2^30 / cosine, one bit per stage
  fdiv_t fd_q [FD_N];
  logic  fdv_q [FD_N];

  for (genvar j = 0; j < FD_N; j++) begin : g_fdiv
    fdiv_t f_in;
    logic  b_in;
    if (j == 0) begin : g_first
      assign f_in = fg_q;
      assign b_in = lens_q[33];
    end else begin : g_next
      assign f_in = fd_q[j-1];
      if (j == 1) begin : g_low
        assign b_in = lens_q[32];
      end else begin : g_zero
        assign b_in = 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      logic [CW:0] rem2;
      fdiv_t       nx;
      if (en) begin
        rem2 = {f_in.rem, b_in};
        nx   = f_in;
        if (rem2 >= {1'b0, f_in.cosv}) begin
          nx.rem = CW'(rem2 - {1'b0, f_in.cosv});
          nx.q   = {f_in.q[FD_N-2:0], 1'b1};
        end else begin
          nx.rem = rem2[CW-1:0];
          nx.q   = {f_in.q[FD_N-2:0], 1'b0};
        end
        fd_q[j] <= nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      for (int j = 0; j < FD_N; j++) fdv_q[j] <= 1'b0;
    end else if (en) begin
      ve_q     <= n1_valid;
      vf_q     <= ve_q;
      vg_q     <= vf_q;
      fdv_q[0] <= vg_q;
      for (int j = 1; j < FD_N; j++) fdv_q[j] <= fdv_q[j-1];
    end
  end

  // stage h: focal length times direction
  logic signed [63:0] tp_q [3];
  fdiv_t              fh_q;
  logic               vh_q;
  always_ff @(posedge clk_i) begin
    logic [FD_N-1:0]    t;
    logic signed [64:0] p;
    if (en) begin
      t = fd_q[FD_N-1].ovf ? '1 : fd_q[FD_N-1].q;
      for (int i = 0; i < 3; i++) begin
        p = $signed({1'b0, t}) * $signed(fd_q[FD_N-1].d[i]);
        tp_q[i] <= p[63:0];
      end
      fh_q <= fd_q[FD_N-1];
    end
  end

  // stage i: focal point minus aperture point, ray origin
  logic signed [VEC_W-1:0] fa_q [3];
  side2_t                  si_q;
  logic                    vi_q;
  always_ff @(posedge clk_i) begin
    logic signed [63:0] fp;
    logic signed [31:0] pin;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        fp = shr0(tp_q[i], 10) + (64'(comp(eye_q, i)) <<< 26);
        fa_q[i] <= fp - $signed(fh_q.ap[i]);
        pin = 32'(comp(eye_q, i)) <<< 6;
        si_q.org[i] <= fh_q.side.use_lens ? sat32(shr0($signed(fh_q.ap[i]), 20)) : pin;
        si_q.dir[i] <= fh_q.d[i];
      end
      si_q.use_lens     <= fh_q.side.use_lens;
      si_q.shutter_time <= fh_q.side.shutter_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
      vi_q <= 1'b0;
    end else if (en) begin
      vh_q <= fdv_q[FD_N-1];
      vi_q <= vh_q;
    end
  end

  // second normalizer: aperture point toward focal point
  logic                    n2_valid;
  logic signed [DIR_W-1:0] d2 [3];
  logic [S2_W-1:0]         n2_side;
  side2_t                  s2;

  tlrg_norm #(.SIDE_W(S2_W)) u_norm_lens (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vi_q),
    .vec_i   (fa_q),
    .side_i  (si_q),
    .valid_o (n2_valid),
    .dir_o   (d2),
    .side_o  (n2_side)
  );
  assign s2 = side2_t'(n2_side);

  // output register
  logic signed [31:0] org_q [3];
  logic signed [31:0] dir_q [3];
  logic signed [31:0] time_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= $signed(s2.org[i]);
        dir_q[i] <= s2.use_lens ? d2[i] : $signed(s2.dir[i]);
      end
      time_q <= $signed(s2.shutter_time);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= n2_valid;
  end

  assign out_valid_o = out_valid_q;
  assign origin_x_o  = org_q[0];
  assign origin_y_o  = org_q[1];
  assign origin_z_o  = org_q[2];
  assign dir_x_o     = dir_q[0];
  assign dir_y_o     = dir_q[1];
  assign dir_z_o     = dir_q[2];
  assign ray_time_o  = time_q;

`ifndef NO_ASSERTIONS
  // an accepted transaction enters the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> va_q)
    else $error("accepted transaction lost at pipeline entry");

  // a stall freezes the valid bits inside the pipeline
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(va_q) && $stable(vg_q) && $stable(vi_q))
    else $error("pipeline moved during stall");

  // a waiting ray stays valid with its payload unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(origin_x_o) &&
      $stable(dir_x_o) && $stable(ray_time_o))
    else $error("waiting ray changed before acceptance");
`endif

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench of the thin lens primary ray generator
module testbench;
  import tlrg_pkg::*;

  // one camera sample as offered on the input channel
  typedef struct packed {
    logic [11:0]        row;
    logic [11:0]        col;
    logic               use_lens;
    logic signed [31:0] shutter_time;
    logic [15:0]        sub_x;
    logic [15:0]        sub_y;
    logic signed [15:0] lens_x;
    logic signed [15:0] lens_y;
  } sample_t;

  // one generated ray
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] ray_time;
  } ray_t;

  localparam int LATENCY = 181;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [63:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [11:0]        row_i = '0;
  logic [11:0]        col_i = '0;
  logic               use_lens_i = 1'b0;
  logic signed [31:0] shutter_time_i = '0;
  logic [15:0]        sub_x_i = '0;
  logic [15:0]        sub_y_i = '0;
  logic signed [15:0] lens_x_i = '0;
  logic signed [15:0] lens_y_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] origin_x_o, origin_y_o, origin_z_o;
  logic signed [31:0] dir_x_o, dir_y_o, dir_z_o, ray_time_o;

  // camera registers as last written
  logic [63:0] cam_regs [7];

  sample_t pending_samples [$];
  ray_t    expected_rays [$];
  int      n_queued = 0;
  int      n_accepted = 0;
  int      n_checked = 0;
  int      n_errors = 0;
  bit      sender_burst = 1'b0;
  bit      receiver_burst = 1'b0;
  bit      hold_arm = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_left = 0;

  thin_lens_primary_ray_gen #(.PIXEL_INDEX_BITS(12)) i_dut (.*);

  always #1 clk_i = ~clk_i;

  // fixed point helpers
  function automatic longint comp21(logic [63:0] r, int i);
    logic signed [20:0] c;
    c = r[21*i +: 21];
    return longint'(c);
  endfunction

  function automatic longint unsigned abs64(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint shr_trunc(longint x, int s);
    if (x < 0) return -longint'(abs64(x) >> s);
    return x >>> s;
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    return x[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // unit vector: scale so the largest magnitude has 31 bits, then divide by length
  function automatic void unit_vec(input longint v[3], output longint d[3]);
    longint unsigned a[3], m, sum, len, q;
    int bl;
    m = 0;
    sum = 0;
    bl = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = abs64(v[i]);
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      d[0] = 0; d[1] = 0; d[2] = 0;
      return;
    end
    while (bl < 64 && (m >> bl) != 0) bl++;
    for (int i = 0; i < 3; i++) begin
      if (bl > 31) a[i] = a[i] >> (bl - 31);
      else if (bl < 31) a[i] = a[i] << (31 - bl);
      sum = sum + a[i] * a[i];
    end
    len = int_sqrt(sum);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = (a[i] << 30) / len;
      d[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  // expected ray of one sample under the current camera registers
  function automatic ray_t trace_ray(sample_t s);
    longint eye[3], cor[3], side[3], up[3], view[3];
    longint diff[3], d[3], org[3], dir[3], fa[3];
    longint su, sv, dotp, cosv, t, aper, lx, ly, comb, fp, ap;
    longint unsigned focus, tq;
    ray_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i]  = comp21(cam_regs[CFG_EYE], i);
      cor[i]  = comp21(cam_regs[CFG_CORNER], i);
      side[i] = comp21(cam_regs[CFG_RIGHT], i);
      up[i]   = comp21(cam_regs[CFG_UP], i);
      view[i] = comp21(cam_regs[CFG_VIEW], i);
    end
    su = longint'((longint'({s.col, s.sub_x}) * longint'(cam_regs[CFG_STEPS][31:0])) >> 24);
    sv = longint'((longint'({s.row, s.sub_y}) * longint'(cam_regs[CFG_STEPS][63:32])) >> 24);
    for (int i = 0; i < 3; i++)
      diff[i] = su * side[i] - sv * up[i] + cor[i] * (64'sd1 << 29) - eye[i] * (64'sd1 << 29);
    unit_vec(diff, d);
    if (!s.use_lens) begin
      for (int i = 0; i < 3; i++) begin
        org[i] = eye[i] * 64;
        dir[i] = d[i];
      end
    end else begin
      focus = cam_regs[CFG_LENS][63:32];
      aper = longint'(cam_regs[CFG_LENS][31:0]);
      lx = longint'(s.lens_x);
      ly = longint'(s.lens_y);
      dotp = 0;
      for (int i = 0; i < 3; i++) dotp = dotp + d[i] * view[i];
      cosv = shr_trunc(dotp, 19);
      // cosine at or behind the view plane saturates to one lsb
      if (cosv <= 0) cosv = 1;
      tq = (focus << 30) / longint'(cosv);
      if (tq > 64'hFFFFFFFF) tq = 64'hFFFFFFFF;
      t = longint'(tq);
      for (int i = 0; i < 3; i++) begin
        comb = up[i] * ly + side[i] * lx;
        fp = shr_trunc(t * d[i], 10) + eye[i] * (64'sd1 << 26);
        ap = shr_trunc(comb, 14) * aper + eye[i] * (64'sd1 << 26);
        fa[i] = fp - ap;
        org[i] = shr_trunc(ap, 20);
      end
      unit_vec(fa, dir);
    end
    r.origin_x = clamp32(org[0]);
    r.origin_y = clamp32(org[1]);
    r.origin_z = clamp32(org[2]);
    r.dir_x = clamp32(dir[0]);
    r.dir_y = clamp32(dir[1]);
    r.dir_z = clamp32(dir[2]);
    r.ray_time = s.shutter_time;
    return r;
  endfunction

  // sample driver
  int      send_gap = 0;
  sample_t cur_sample;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_rays.push_back(trace_ray(cur_sample));
        n_accepted++;
        send_gap = sender_burst ? 0 : $urandom_range(0, 11);
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          cur_sample = pending_samples.pop_front();
          in_valid_i <= 1'b1;
          row_i <= cur_sample.row;
          col_i <= cur_sample.col;
          use_lens_i <= cur_sample.use_lens;
          shutter_time_i <= cur_sample.shutter_time;
          sub_x_i <= cur_sample.sub_x;
          sub_y_i <= cur_sample.sub_y;
          lens_x_i <= cur_sample.lens_x;
          lens_y_i <= cur_sample.lens_y;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the pipeline fills and backs up
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end
  end

  // ray monitor and checker
  int   stall_left = 0;
  ray_t got_ray, want_ray;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left > 0) stall_left--;
      if (out_valid_o && out_ready_i) begin
        got_ray = '{origin_x_o, origin_y_o, origin_z_o, dir_x_o, dir_y_o, dir_z_o, ray_time_o};
        if (expected_rays.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected ray %h", got_ray);
        end else begin
          want_ray = expected_rays.pop_front();
          if (got_ray.origin_x !== want_ray.origin_x || got_ray.origin_y !== want_ray.origin_y ||
              got_ray.origin_z !== want_ray.origin_z || got_ray.dir_x !== want_ray.dir_x ||
              got_ray.dir_y !== want_ray.dir_y || got_ray.dir_z !== want_ray.dir_z ||
              got_ray.ray_time !== want_ray.ray_time) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("ray mismatch expected org %0d %0d %0d dir %0d %0d %0d time %0d",
                       want_ray.origin_x, want_ray.origin_y, want_ray.origin_z,
                       want_ray.dir_x, want_ray.dir_y, want_ray.dir_z, want_ray.ray_time);
              $display("             actual   org %0d %0d %0d dir %0d %0d %0d time %0d",
                       got_ray.origin_x, got_ray.origin_y, got_ray.origin_z,
                       got_ray.dir_x, got_ray.dir_y, got_ray.dir_z, got_ray.ray_time);
            end
          end
          n_checked++;
        end
        stall_left = receiver_burst ? 0 : $urandom_range(0, 11);
      end
      out_ready_i <= (stall_left == 0) && (hold_left == 0);
    end
  end

  // camera register write over the configuration channel
  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cam_regs[idx] = val;
  endtask

  function automatic logic [63:0] pack3(int a, int b, int c);
    return {1'b0, c[20:0], b[20:0], a[20:0]};
  endfunction

  function automatic sample_t rand_sample();
    sample_t      s;
    logic [127:0] rbits;
    rbits = {$urandom, $urandom, $urandom, $urandom};
    s = rbits[$bits(sample_t)-1:0];
    // bias toward edge rows and columns now and then
    if ($urandom_range(0, 7) == 0) s.row = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    if ($urandom_range(0, 7) == 0) s.col = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    return s;
  endfunction

  task automatic queue_sample(sample_t s);
    pending_samples.push_back(s);
    n_queued++;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || n_checked != n_accepted || expected_rays.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
  endtask

  task automatic write_all(logic [63:0] v [7]);
    for (int i = 0; i < 7; i++) write_reg(cfg_idx_e'(i), v[i]);
  endtask

  // directed samples: field extremes in both modes
  task automatic queue_directed();
    sample_t s;
    for (int k = 0; k < 20; k++) begin
      s = rand_sample();
      s.use_lens = k[0];
      case (k % 5)
        0: begin
          s.row = '0; s.col = '0; s.sub_x = '0; s.sub_y = '0;
          s.lens_x = 16'sh8000; s.lens_y = 16'sh8000; s.shutter_time = 32'sh80000000;
        end
        1: begin
          s.row = '1; s.col = '1; s.sub_x = '1; s.sub_y = '1;
          s.lens_x = 16'sh7FFF; s.lens_y = 16'sh7FFF; s.shutter_time = 32'sh7FFFFFFF;
        end
        2: begin
          s.row = '0; s.col = '1; s.lens_x = '0; s.lens_y = '0; s.shutter_time = '0;
        end
        3: begin
          s.row = '1; s.col = '0; s.lens_x = 16'sh7FFF; s.lens_y = 16'sh8000;
        end
        default: ;
      endcase
      queue_sample(s);
    end
  endtask

  task automatic queue_random(int n);
    for (int k = 0; k < n; k++) queue_sample(rand_sample());
  endtask

  logic [63:0] setting [7];

  // run limit
  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < 7; i++) cam_regs[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers at reset: zero vectors and non-positive cosine
    queue_directed();
    queue_random(40);
    drain();

    // plausible camera looking down -z
    setting[CFG_EYE]    = pack3(0, 0, 5 << 10);
    setting[CFG_CORNER] = pack3(-(2 << 10), 3 << 9, 0);
    setting[CFG_RIGHT]  = pack3(1 << 19, 0, 0);
    setting[CFG_UP]     = pack3(0, 1 << 19, 0);
    setting[CFG_VIEW]   = pack3(0, 0, -(1 << 19));
    setting[CFG_STEPS]  = {32'd1 << 18, 32'd1 << 18};
    setting[CFG_LENS]   = {32'd5 << 16, 32'd6554};
    write_all(setting);
    queue_directed();
    sender_burst = 1'b1;
    receiver_burst = 1'b1;
    queue_random(120);
    drain();
    sender_burst = 1'b0;
    receiver_burst = 1'b0;
    queue_random(120);
    drain();

    // all ones, then maximum positive components
    for (int i = 0; i < 7; i++) setting[i] = '1;
    write_all(setting);
    queue_directed();
    queue_random(80);
    drain();
    for (int i = 0; i < 5; i++) setting[i] = pack3(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    setting[CFG_VIEW] = pack3(-(1 << 20), -(1 << 20), -(1 << 20));
    setting[CFG_STEPS] = '1;
    setting[CFG_LENS] = {32'hFFFFFFFF, 32'hFFFFFFFF};
    write_all(setting);
    queue_random(80);
    drain();

    // random camera settings, one with a long output hold-off
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < 7; i++) setting[i] = {$urandom, $urandom};
      write_all(setting);
      if (p == 1) hold_arm = 1'b1;
      queue_random(100);
      drain();
    end

    if (n_errors == 0 && expected_rays.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
